/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; the using scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock outside reset
`define PGT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define PGT_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* rtl/core/pgt_pkg.sv */
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared types and constants of the gravity trajectory stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgt_pkg;

	localparam int STEP_BITS = 8;
	localparam int DT_BITS   = 17;
	localparam int DT_FRAC   = 16;
	localparam int GM_BITS   = 47;
	localparam int FIELD_BITS = 48;
	localparam int CFG_IDX_BITS = 2;
	localparam logic [DT_BITS-1:0] DT_ONE = 17'h10000;
	localparam logic [DT_BITS-1:0] DT_RESET = 17'd655;

	localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_STEP  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GRAV_PARAM = 2'd1;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic                 start;
		alu_op_t              op;
		logic [STEP_BITS-1:0] steps;
	} alu_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQRT,
		ST_MAG,
		ST_AMUL,
		ST_ADIV,
		ST_DVMUL,
		ST_PMUL,
		ST_DONE
	} pgt_state_t;

endpackage

`default_nettype wire

/* rtl/core/pgt_alu.sv */
// ----------------------------------------------------------------------------
// pgt_alu
// Shared bit-serial unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgt_alu
	import pgt_pkg::*;
#(
	parameter int ACC_BITS = 98
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire alu_req_t            req,
	input  wire logic [ACC_BITS-1:0] opa,
	input  wire logic [ACC_BITS-1:0] opb,
	output logic                     done,
	output logic [ACC_BITS-1:0]      result
);

	alu_op_t              op_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ACC_BITS:0]    acc_q;
	logic [ACC_BITS-1:0]  opa_q;
	logic [ACC_BITS-1:0]  shf_q;
	logic [ACC_BITS-1:0]  res_q;

	logic [ACC_BITS:0]   x;
	logic [ACC_BITS:0]   y;
	logic                sub;
	logic [ACC_BITS+1:0] sum;
	logic                ge;
	logic [ACC_BITS:0]   acc_d;
	logic [ACC_BITS-1:0] shf_d;

	always_comb begin
		case (op_q)
			ALU_MUL: begin
				x   = {acc_q[ACC_BITS-1:0], 1'b0};
				y   = shf_q[ACC_BITS-1] ? {1'b0, opa_q} : '0;
				sub = 1'b0;
			end
			ALU_DIV: begin
				x   = {acc_q[ACC_BITS-1:0], shf_q[ACC_BITS-1]};
				y   = {1'b0, opa_q};
				sub = 1'b1;
			end
			ALU_SQRT: begin
				x   = {acc_q[ACC_BITS-2:0], shf_q[ACC_BITS-1:ACC_BITS-2]};
				y   = {1'b0, res_q[ACC_BITS-3:0], 2'b01};
				sub = 1'b1;
			end
			default: begin
				x   = '0;
				y   = '0;
				sub = 1'b0;
			end
		endcase
		sum = {1'b0, x} + ({1'b0, y} ^ {(ACC_BITS+2){sub}}) + (ACC_BITS+2)'(sub);
		ge  = sub & ~sum[ACC_BITS+1];
		if (!sub || ge) begin
			acc_d = sum[ACC_BITS:0];
		end else begin
			acc_d = x;
		end
		if (op_q == ALU_SQRT) begin
			shf_d = {shf_q[ACC_BITS-3:0], 2'b00};
		end else begin
			shf_d = {shf_q[ACC_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ALU_MUL;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			opa_q <= opa;
			shf_q <= opb;
			res_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_d;
			shf_q <= shf_d;
			res_q <= {res_q[ACC_BITS-2:0], ge};
		end
	end

	assign done   = done_q;
	assign result = (op_q == ALU_MUL) ? acc_q[ACC_BITS-1:0] : res_q;

endmodule

`default_nettype wire

/* rtl/core/point_gravity_trajectory_step.sv */
// ----------------------------------------------------------------------------
// point_gravity_trajectory_step
// Semi-implicit Euler step of a point mass around an attractor at the origin.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets time_step
//   (index 0) and grav_param (index 1); always ready, write only when idle.
//   in channel takes one request: op 0 loads position and velocity, op 1
//   advances one tick. in_ready is high only while the sequencer is idle.
//   out channel carries one path vertex per tick whose position was off the
//   origin, plus a flag for any clipping in that tick.
// Work: a tick at the origin runs only the three position multiplies; a tick
//   off the origin also runs three squares, a square root, a divide and, per
//   axis, a multiply, a divide and a velocity multiply. All of them run on the
//   single bit-serial unit, one bit (root: two bits) per cycle.
// Stall: a finished vertex sits in an output register; the next request is
//   accepted meanwhile, and a later tick that emits a vertex waits at its end until it drains.
// Reset: state and velocity clear to zero, time_step 655, grav_param 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_gravity_trajectory_step
	import pgt_pkg::*;
#(
	parameter int WORD_BITS = 48,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  wire logic [GM_BITS-1:0]             cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           op,
	input  wire logic signed [FIELD_BITS-1:0]   pos_x,
	input  wire logic signed [FIELD_BITS-1:0]   pos_y,
	input  wire logic signed [FIELD_BITS-1:0]   pos_z,
	input  wire logic signed [FIELD_BITS-1:0]   vel_x,
	input  wire logic signed [FIELD_BITS-1:0]   vel_y,
	input  wire logic signed [FIELD_BITS-1:0]   vel_z,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [FIELD_BITS-1:0]        vertex_x,
	output logic signed [FIELD_BITS-1:0]        vertex_y,
	output logic signed [FIELD_BITS-1:0]        vertex_z,
	output logic                                saturated
);

	localparam int W = WORD_BITS;
	localparam int RAW_A = (2*W+2 > FIELD_BITS+2*FRAC_BITS) ? 2*W+2 : FIELD_BITS+2*FRAC_BITS;
	localparam int A = RAW_A;

	pgt_state_t state_q, state_d;
	logic [1:0] ax_q, ax_d;
	logic       issue_q;

	logic [DT_BITS-1:0] time_step_q;
	logic [GM_BITS-1:0] grav_q;
	logic [DT_BITS-1:0] dt_q;

	logic signed [W-1:0] pos_q [3];
	logic signed [W-1:0] vel_q [3];
	logic signed [FIELD_BITS-1:0] vtx_q [3];

	logic [A-1:0] dist_q;
	logic [W-1:0] root_q;
	logic [W-2:0] mag_q;
	logic [A-1:0] tmp_q;
	logic         flag_q;
	logic         emit_q;

	logic         out_valid_q;
	logic signed [FIELD_BITS-1:0] out_x_q, out_y_q, out_z_q;
	logic         out_sat_q;

	alu_req_t     alu_req;
	logic [A-1:0] alu_a, alu_b;
	logic         alu_done;
	logic [A-1:0] alu_res;

	logic         tick_acc, load_acc, slot_free;
	logic signed [W-1:0] pos_sel, vel_sel;
	logic [W-1:0] pos_mag, vel_mag;
	logic         q_clip;
	logic [W-2:0] q_clipped;
	logic [W-1:0] step_mag;
	logic [W:0]   vel_sum, pos_sum;
	logic         pos_neg_dv;

	function automatic logic signed [W-1:0] load_clip(input logic signed [FIELD_BITS-1:0] v);
		logic signed [64:0] e, hi, lo;
		e  = 65'(v);
		hi = (65'sd1 <<< (W-1)) - 65'sd1;
		lo = -hi - 65'sd1;
		if (e > hi) begin
			return W'(hi);
		end
		if (e < lo) begin
			return W'(lo);
		end
		return W'(e);
	endfunction

	function automatic logic [W-1:0] abs_of(input logic signed [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// bit W flags clipping, low bits hold the sum
	function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] m,
		input logic neg);
		logic [W:0] ae, me, s;
		ae = {a[W-1], a};
		me = neg ? (~{1'b0, m} + 1'b1) : {1'b0, m};
		s  = ae + me;
		if (s[W] != s[W-1]) begin
			return {1'b1, s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}};
		end
		return {1'b0, s[W-1:0]};
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign tick_acc  = in_valid && in_ready && op;
	assign load_acc  = in_valid && in_ready && !op;
	assign slot_free = !out_valid_q || out_ready;

	assign pos_sel = pos_q[ax_q];
	assign vel_sel = vel_q[ax_q];
	assign pos_mag = abs_of(pos_sel);
	assign vel_mag = abs_of(vel_sel);
	assign q_clip  = |alu_res[A-1:W-1];
	assign q_clipped = q_clip ? {(W-1){1'b1}} : alu_res[W-2:0];
	assign step_mag = alu_res[W-1+DT_FRAC:DT_FRAC];
	assign pos_neg_dv = !pos_sel[W-1] && (pos_sel != '0);
	assign vel_sum = sat_add(vel_sel, step_mag, pos_neg_dv);
	assign pos_sum = sat_add(pos_sel, step_mag, vel_sel[W-1]);

	pgt_alu #(.ACC_BITS(A)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (alu_a),
		.opb    (alu_b),
		.done   (alu_done),
		.result (alu_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		ax_d    = ax_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_acc) begin
					ax_d = 2'd0;
					if ((pos_q[0] != '0) || (pos_q[1] != '0) || (pos_q[2] != '0)) begin
						state_d = ST_SQ;
					end else begin
						state_d = ST_PMUL;
					end
				end
			end
			ST_SQ: begin
				if (alu_done) begin
					if (ax_q == 2'd2) begin
						state_d = ST_SQRT;
						ax_d    = 2'd0;
					end else begin
						ax_d = ax_q + 2'd1;
					end
				end
			end
			ST_SQRT: if (alu_done) state_d = ST_MAG;
			ST_MAG:  if (alu_done) state_d = ST_AMUL;
			ST_AMUL: if (alu_done) state_d = ST_ADIV;
			ST_ADIV: if (alu_done) state_d = ST_DVMUL;
			ST_DVMUL: begin
				if (alu_done) begin
					if (ax_q == 2'd2) begin
						state_d = ST_PMUL;
						ax_d    = 2'd0;
					end else begin
						state_d = ST_AMUL;
						ax_d    = ax_q + 2'd1;
					end
				end
			end
			ST_PMUL: begin
				if (alu_done) begin
					if (ax_q == 2'd2) begin
						state_d = ST_DONE;
					end else begin
						ax_d = ax_q + 2'd1;
					end
				end
			end
			ST_DONE: if (!emit_q || slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// unit operands
	always_comb begin
		alu_req.start = issue_q;
		alu_req.op    = ALU_MUL;
		alu_req.steps = STEP_BITS'(DT_BITS);
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			ST_SQ: begin
				alu_req.steps = STEP_BITS'(W);
				alu_a = A'(pos_mag);
				alu_b = {pos_mag, {(A-W){1'b0}}};
			end
			ST_SQRT: begin
				alu_req.op    = ALU_SQRT;
				alu_req.steps = STEP_BITS'(A/2);
				alu_b = dist_q;
			end
			ST_MAG: begin
				alu_req.op    = ALU_DIV;
				alu_req.steps = STEP_BITS'(A);
				alu_a = dist_q;
				alu_b = A'({grav_q, {(2*FRAC_BITS){1'b0}}});
			end
			ST_AMUL: begin
				alu_req.steps = STEP_BITS'(W-1);
				alu_a = A'(pos_mag);
				alu_b = {mag_q, {(A-W+1){1'b0}}};
			end
			ST_ADIV: begin
				alu_req.op    = ALU_DIV;
				alu_req.steps = STEP_BITS'(A);
				alu_a = A'(root_q);
				alu_b = tmp_q;
			end
			ST_DVMUL: begin
				alu_a = tmp_q;
				alu_b = {dt_q, {(A-DT_BITS){1'b0}}};
			end
			ST_PMUL: begin
				alu_a = A'(vel_mag);
				alu_b = {dt_q, {(A-DT_BITS){1'b0}}};
			end
			default: begin
				alu_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= 2'd0;
			issue_q     <= 1'b0;
			time_step_q <= DT_RESET;
			grav_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			ax_q    <= ax_d;
			issue_q <= (tick_acc || alu_done) && (state_d != ST_IDLE) && (state_d != ST_DONE);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TIME_STEP) begin
					time_step_q <= cfg_data[DT_BITS-1:0];
				end else if (cfg_index == CFG_GRAV_PARAM) begin
					grav_q <= cfg_data;
				end
			end
			if (load_acc) begin
				pos_q[0] <= load_clip(pos_x);
				pos_q[1] <= load_clip(pos_y);
				pos_q[2] <= load_clip(pos_z);
				vel_q[0] <= load_clip(vel_x);
				vel_q[1] <= load_clip(vel_y);
				vel_q[2] <= load_clip(vel_z);
			end
			if (alu_done && state_q == ST_DVMUL) begin
				vel_q[ax_q] <= vel_sum[W-1:0];
			end
			if (alu_done && state_q == ST_PMUL) begin
				pos_q[ax_q] <= pos_sum[W-1:0];
			end
			if (state_q == ST_DONE && emit_q && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			emit_q <= (pos_q[0] != '0) || (pos_q[1] != '0) || (pos_q[2] != '0);
			dt_q   <= (time_step_q > DT_ONE) ? DT_ONE : time_step_q;
			dist_q <= '0;
			flag_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				vtx_q[i] <= FIELD_BITS'(pos_q[i]);
			end
		end
		if (alu_done) begin
			case (state_q)
				ST_SQ:   dist_q <= dist_q + alu_res;
				ST_SQRT: root_q <= alu_res[W-1:0];
				ST_MAG: begin
					mag_q  <= q_clipped;
					flag_q <= flag_q | q_clip;
				end
				ST_AMUL: tmp_q <= alu_res;
				ST_ADIV: begin
					tmp_q  <= A'(q_clipped);
					flag_q <= flag_q | q_clip;
				end
				ST_DVMUL: flag_q <= flag_q | vel_sum[W];
				ST_PMUL:  flag_q <= flag_q | pos_sum[W];
				default: ;
			endcase
		end
		if (state_q == ST_DONE && emit_q && slot_free) begin
			out_x_q   <= vtx_q[0];
			out_y_q   <= vtx_q[1];
			out_z_q   <= vtx_q[2];
			out_sat_q <= flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex_x  = out_x_q;
	assign vertex_y  = out_y_q;
	assign vertex_z  = out_z_q;
	assign saturated = out_sat_q;

endmodule

`default_nettype wire

/* rtl/core/pgt_checker.sv */
// ----------------------------------------------------------------------------
// pgt_checker
// Port-level checks of the trajectory stepper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pgt_checker
	import pgt_pkg::*;
(
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         cfg_ready,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         op,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [FIELD_BITS-1:0] vertex_x,
	input wire logic                         saturated
);

	`PGT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(saturated), "stalled vertex changed")
	`PGT_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")
	`PGT_ASSERT(a_tick_busy, in_valid && in_ready && op |=> !in_ready, "tick request did not start work")
	`PGT_ASSERT(a_load_silent, in_valid && in_ready && !op |=> !$rose(out_valid), "load request produced a vertex")
	`PGT_ASSERT(a_out_after_work, $rose(out_valid) |-> $past(!in_ready), "vertex without a tick in progress")

endmodule

bind point_gravity_trajectory_step pgt_checker u_pgt_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the gravity trajectory stepper against a bit-exact predictor.
// Loads and ticks go in over valid/ready with random gaps. Vertices come back
// under random output stalls, and each is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import pgt_pkg::*;

	localparam logic [127:0] WMAX = (128'd1 << 47) - 1;
	localparam int SETTLE = 1200;
	localparam int LIMIT = 4000000;

	typedef struct {
		logic                        op;
		logic signed [FIELD_BITS-1:0] px, py, pz, vx, vy, vz;
	} body_req_t;

	typedef struct {
		logic [FIELD_BITS-1:0] x, y, z;
		logic                  sat;
	} vertex_t;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [GM_BITS-1:0] cfg_data = '0;
	logic in_valid = 0, in_ready, op = 0;
	logic signed [FIELD_BITS-1:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [FIELD_BITS-1:0] vel_x = 0, vel_y = 0, vel_z = 0;
	logic out_valid, out_ready = 0, saturated;
	logic signed [FIELD_BITS-1:0] vertex_x, vertex_y, vertex_z;

	point_gravity_trajectory_step i_dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// predictor state
	logic [DT_BITS-1:0] dt_reg = DT_RESET;
	logic [GM_BITS-1:0] gm_reg = '0;
	logic signed [FIELD_BITS-1:0] pos_st[3], vel_st[3];
	logic clip_seen;

	body_req_t pending_reqs[$];
	vertex_t vertices_due[$];
	body_req_t cur_req;
	int send_gap = 0, recv_gap = 0, errors = 0;
	bit calm = 0;
	longint cycles = 0;

	initial begin
		for (int i = 0; i < 3; i++) begin
			pos_st[i] = 0;
			vel_st[i] = 0;
		end
	end

	function automatic logic [127:0] clip(logic [127:0] q, logic [127:0] lim);
		if (q > lim) begin
			clip_seen = 1;
			return lim;
		end
		return q;
	endfunction

	function automatic logic signed [47:0] from_mag(logic neg, logic [127:0] q);
		logic [127:0] m;
		m = clip(q, neg ? WMAX + 1 : WMAX);
		return neg ? -m[47:0] : m[47:0];
	endfunction

	function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
			logic signed [47:0] b);
		logic [48:0] s;
		s = {a[47], a} + {b[47], b};
		if (s[48] != s[47]) begin
			clip_seen = 1;
			return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end
		return s[47:0];
	endfunction

	function automatic logic [127:0] mag_of(logic signed [47:0] v);
		logic [47:0] u;
		u = v[47] ? -v : v;
		return {80'd0, u};
	endfunction

	// one accepted request through the predictor
	function automatic void advance_body(body_req_t r);
		logic [127:0] m[3], dsq, root, c, mag, am, dt;
		logic emit;
		vertex_t vt;
		if (r.op == 1'b0) begin
			pos_st[0] = r.px; pos_st[1] = r.py; pos_st[2] = r.pz;
			vel_st[0] = r.vx; vel_st[1] = r.vy; vel_st[2] = r.vz;
			return;
		end
		clip_seen = 0;
		dt = (dt_reg > DT_ONE) ? DT_ONE : dt_reg;
		emit = (pos_st[0] != 0) || (pos_st[1] != 0) || (pos_st[2] != 0);
		if (emit) begin
			vt.x = pos_st[0]; vt.y = pos_st[1]; vt.z = pos_st[2];
			dsq = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = mag_of(pos_st[i]);
				dsq = dsq + m[i] * m[i];
			end
			root = 0;
			for (int b = 63; b >= 0; b--) begin
				c = root | (128'd1 << b);
				if (dsq >= c * c)
					root = c;
			end
			mag = clip(({81'd0, gm_reg} << 32) / dsq, WMAX);
			for (int i = 0; i < 3; i++) begin
				am = clip((m[i] * mag) / root, WMAX);
				vel_st[i] = sat_add(vel_st[i],
					from_mag(pos_st[i] > 0, (am * dt) >> DT_FRAC));
			end
		end
		for (int i = 0; i < 3; i++)
			pos_st[i] = sat_add(pos_st[i],
				from_mag(vel_st[i] < 0, (mag_of(vel_st[i]) * dt) >> DT_FRAC));
		if (emit) begin
			vt.sat = clip_seen;
			vertices_due.push_back(vt);
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (in_valid && in_ready)
			advance_body(cur_req);
		if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 0;
			end else if (!calm && $urandom_range(0, 19) == 0) begin
				send_gap = $urandom_range(1, 18);
				in_valid <= 0;
			end else if (pending_reqs.size() > 0) begin
				cur_req = pending_reqs.pop_front();
				in_valid <= 1;
				op <= cur_req.op;
				pos_x <= cur_req.px; pos_y <= cur_req.py; pos_z <= cur_req.pz;
				vel_x <= cur_req.vx; vel_y <= cur_req.vy; vel_z <= cur_req.vz;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// vertex monitor and output stalls
	always @(posedge clk) begin
		vertex_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_TIME_STEP)
				dt_reg = cfg_data[DT_BITS-1:0];
			else if (cfg_index == CFG_GRAV_PARAM)
				gm_reg = cfg_data;
		end
		if (out_valid && out_ready) begin
			if (vertices_due.size() == 0) begin
				$display("%0t: vertex with nothing expected: %h %h %h", $time,
					vertex_x, vertex_y, vertex_z);
				errors++;
			end else begin
				e = vertices_due.pop_front();
				if (vertex_x !== e.x) begin
					$display("%0t: vertex_x expected %h actual %h", $time, e.x, vertex_x);
					errors++;
				end
				if (vertex_y !== e.y) begin
					$display("%0t: vertex_y expected %h actual %h", $time, e.y, vertex_y);
					errors++;
				end
				if (vertex_z !== e.z) begin
					$display("%0t: vertex_z expected %h actual %h", $time, e.z, vertex_z);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, e.sat,
						saturated);
					errors++;
				end
			end
		end
		if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 0;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			recv_gap = $urandom_range(1, 18);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [GM_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		wait (pending_reqs.size() == 0 && !in_valid && vertices_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [47:0] rand_word();
		logic [63:0] r;
		int k;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return r[47:0];
			1: return {1'b0, {47{1'b1}}};
			2: return {1'b1, 47'd0};
			3: return 0;
			default: begin
				k = $urandom_range(4, 40);
				r = r & ((64'd1 << k) - 1);
				return r[0] ? -r[47:0] : r[47:0];
			end
		endcase
	endfunction

	task automatic push_req(logic o, logic signed [47:0] a, b, c, d, e, f);
		body_req_t r;
		r.op = o;
		r.px = a; r.py = b; r.pz = c; r.vx = d; r.vy = e; r.vz = f;
		pending_reqs.push_back(r);
	endtask

	task automatic push_tick;
		push_req(1, 0, 0, 0, 0, 0, 0);
	endtask

	// random orbits: a load (one time in ten a tick instead), then a run of ticks
	task automatic random_orbits(int count);
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0)
				push_tick;
			else
				push_req(0, rand_word(), rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word());
			n++;
			for (int t = $urandom_range(1, 8); t > 0 && n < count; t--, n++)
				push_tick;
		end
	endtask

	initial begin
		logic signed [47:0] hi, lo;
		hi = {1'b0, {47{1'b1}}};
		lo = {1'b1, 47'd0};
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// defaults: tick at origin, then drift off it, extremes
		push_tick;
		push_req(0, 0, 0, 0, 48'sd65536, -48'sd65536, 48'sd3);
		push_tick; push_tick;
		push_req(0, hi, hi, hi, hi, hi, hi);
		push_tick;
		push_req(0, lo, lo, lo, lo, lo, lo);
		push_tick;
		drain;

		write_reg(CFG_TIME_STEP, DT_ONE);
		write_reg(CFG_GRAV_PARAM, {GM_BITS{1'b1}});
		write_reg(2, $urandom);
		write_reg(3, {$urandom, $urandom});
		push_req(0, 48'sd1, 0, 0, 0, 0, 0);
		push_tick; push_tick;
		push_req(0, -48'sd1, -48'sd1, 48'sd1, lo, hi, 0);
		push_tick;
		push_req(0, hi, lo, 48'sd65536, 0, 0, 0);
		push_tick; push_tick;
		drain;

		write_reg(CFG_TIME_STEP, {DT_BITS{1'b1}});
		write_reg(CFG_GRAV_PARAM, 47'd1);
		push_req(0, 48'sd655360, -48'sd327680, 48'sd1, 48'sd100, 0, -48'sd7);
		push_tick; push_tick;
		drain;

		write_reg(CFG_TIME_STEP, 0);
		write_reg(CFG_GRAV_PARAM, 47'h0000_0010_0000);
		random_orbits(100);
		drain;

		for (int ph = 0; ph < 3; ph++) begin
			write_reg(CFG_TIME_STEP, $urandom_range(0, 70000));
			write_reg(CFG_GRAV_PARAM, {$urandom, $urandom} >> $urandom_range(17, 60));
			random_orbits(110);
			drain;
		end

		calm = 1;
		write_reg(CFG_TIME_STEP, $urandom_range(1, 65536));
		write_reg(CFG_GRAV_PARAM, {$urandom, $urandom} >> $urandom_range(17, 40));
		random_orbits(50);
		drain;

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
